FILE: hw/rtl/symmetric_3x3_jacobi_eigenvalues_assert.svh
// Assertion macros for the 3x3 Jacobi eigenvalue block.
// Needs clk_i and rst_ni in the scope of the module that expands them.
`ifndef SYMMETRIC_3X3_JACOBI_EIGENVALUES_ASSERT_SVH
`define SYMMETRIC_3X3_JACOBI_EIGENVALUES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SJEV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sjev: same-cycle check failed");
`define SJEV_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sjev: next-cycle check failed");
`else
`define SJEV_ASSERT_IMP(lbl, pre, post)
`define SJEV_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: hw/rtl/sjev_pkg.sv
// Package for the 3x3 Jacobi eigenvalue block: widths, codes and CORDIC tables.
// Tables are built at elaboration by constant functions; no dependencies.
`timescale 1ns / 1ps
package sjev_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ANG_W        = 64;
  localparam int unsigned ANG_FRAC     = 60;
  localparam int unsigned SC_FRAC      = 30;
  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned ROT_W        = 6;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ACC_W        = 36;
  localparam int unsigned NUM_OPS      = 13;
  localparam int unsigned OP_W         = $clog2(NUM_OPS);
  localparam int unsigned IN_W         = 6 * DATA_W;
  localparam int unsigned OUT_W        = 104;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [ROT_W-1:0]     ROT_LIMIT_RST = 6'd50;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef ang_t ang_tab_t [CORDIC_STEPS];

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SEARCH = 11'b000_0000_0010,
    ST_VNORM  = 11'b000_0000_0100,
    ST_VQUAD  = 11'b000_0000_1000,
    ST_VITER  = 11'b000_0001_0000,
    ST_SINIT  = 11'b000_0010_0000,
    ST_SITER  = 11'b000_0100_0000,
    ST_SCFIN  = 11'b000_1000_0000,
    ST_MUL    = 11'b001_0000_0000,
    ST_WB     = 11'b010_0000_0000,
    ST_FINISH = 11'b100_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    PAIR_01 = 2'd0,
    PAIR_02 = 2'd1,
    PAIR_12 = 2'd2
  } pair_e;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_CC   = 3'd1,
    DST_SS   = 3'd2,
    DST_SC2  = 3'd3,
    DST_NPP  = 3'd4,
    DST_NQQ  = 3'd5,
    DST_NRP  = 3'd6,
    DST_NRQ  = 3'd7
  } dest_e;

  // Control of one multiply-accumulate step.
  typedef struct packed {
    logic signed [DATA_W:0]   opa;
    logic signed [DATA_W-1:0] opb;
    logic                     sub;
    logic                     first;
    dest_e                    dest;
  } mul_ctl_t;

  // Restoring division, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) from its series, 60 fraction bits.
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] t;
    logic [63:0] sum;
    p   = udiv64(64'd1 << ANG_FRAC, n);
    nn  = n * n;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t   = udiv64(p, 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - t : sum + t;
        p   = udiv64(p, nn);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] rbit;
    v    = v_in;
    res  = '0;
    rbit = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rbit > v) rbit = rbit >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (rbit != 64'd0) begin
        if (v >= res + rbit) begin
          v   = v - (res + rbit);
          res = (res >> 1) + rbit;
        end else begin
          res = res >> 1;
        end
        rbit = rbit >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] gain_k_f();
    logic [63:0] g;
    g = 64'd1 << ANG_FRAC;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      g = g + (g >> (2 * i));
    end
    return udiv64(64'd1 << ANG_FRAC, isqrt64(g));
  endfunction

  function automatic ang_tab_t build_atan_tab();
    ang_tab_t tab;
    tab[0] = ang_t'(atan_inv(64'd2) + atan_inv(64'd3));
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      tab[i] = ang_t'(atan_inv(64'd1 << i));
    end
    return tab;
  endfunction

  localparam ang_tab_t ATAN_TAB   = build_atan_tab();
  localparam ang_t     PI_QUARTER = ATAN_TAB[0];
  localparam ang_t     GAIN_K     = ang_t'(gain_k_f());

endpackage

FILE: hw/rtl/symmetric_3x3_jacobi_eigenvalues.sv
// Jacobi eigenvalue solver for one symmetric 3x3 matrix, Q16.16 in and out.
// Depends on sjev_pkg and symmetric_3x3_jacobi_eigenvalues_assert.svh.
`timescale 1ns / 1ps
`include "symmetric_3x3_jacobi_eigenvalues_assert.svh"
// One matrix is a single transaction in and a single transaction out. The block
// takes a matrix only when idle and works on it alone: it picks the pivot, then
// for each rotation runs normalizing shifts, a quadrant step, 20 vectoring CORDIC
// steps (skipped when the diagonal pair is equal), the sine/cosine CORDIC, 13
// products on the shared 32x32 multiplier and a write-back. When done it waits
// in its finish state until the output register is free. A finished result
// waits in the output register while the next matrix is taken.
module symmetric_3x3_jacobi_eigenvalues (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sjev_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sjev_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // entry_00, entry_01, entry_02, entry_11, entry_12, entry_22 (32 bits each)
  input  logic [sjev_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // eig_low, eig_mid, eig_high (32 each), rotations_done (6), converged, saturated
  output logic [sjev_pkg::OUT_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned DW = sjev_pkg::DATA_W;
  localparam logic signed [sjev_pkg::ACC_W-1:0] SatMax =
    sjev_pkg::ACC_W'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [sjev_pkg::ACC_W-1:0] SatMin = -SatMax - 1;
  localparam sjev_pkg::ang_t SmallMag = sjev_pkg::ang_t'(1) <<< 50;
  localparam sjev_pkg::ang_t NormMag  = sjev_pkg::ang_t'(1) <<< 58;
  localparam sjev_pkg::ang_t ScHalf   =
    sjev_pkg::ang_t'(1) <<< (sjev_pkg::ANG_FRAC - sjev_pkg::SC_FRAC - 1);

  sjev_pkg::state_e state_q, state_d;
  sjev_pkg::pair_e  pair_q, pair_d, best_pair;

  logic signed [DW-1:0] a00_q, a01_q, a02_q, a11_q, a12_q, a22_q;
  logic signed [DW-1:0] a00_d, a01_d, a02_d, a11_d, a12_d, a22_d;
  logic signed [DW-1:0] app_q, aqq_q, apq_q, rp_q, rq_q;
  logic signed [DW-1:0] app_d, aqq_d, apq_d, rp_d, rq_d;
  logic signed [DW-1:0] c_q, s_q, cc_q, ss_q, sc2_q;
  logic signed [DW-1:0] c_d, s_d, cc_d, ss_d, sc2_d;
  logic signed [DW-1:0] npp_q, nqq_q, nrp_q, nrq_q;
  logic signed [DW-1:0] npp_d, nqq_d, nrp_d, nrq_d;
  logic [sjev_pkg::ROT_W-1:0] rot_limit_q, done_q, done_d;
  logic [sjev_pkg::THR_W-1:0] thr_q;
  logic conv_q, conv_d, clip_q, clip_d;
  sjev_pkg::ang_t cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [sjev_pkg::STEP_W-1:0] step_q, step_d;
  logic [sjev_pkg::OP_W-1:0] op_q, op_d;
  logic phase_q, phase_d;
  logic [63:0] prod_q, prod_d;
  logic neg_q, neg_d;
  logic signed [sjev_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [sjev_pkg::OUT_W-1:0] out_q;
  logic out_valid_q;
  logic out_load;

  // Pivot search over the three off-diagonals.
  logic [DW-1:0] mag01, mag02, mag12, best;
  logic signed [DW-1:0] sel_app, sel_aqq, sel_apq, sel_rp, sel_rq;
  logic signed [DW:0] diff;

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    mag01     = mag_f(a01_q);
    mag02     = mag_f(a02_q);
    mag12     = mag_f(a12_q);
    best      = mag01;
    best_pair = sjev_pkg::PAIR_01;
    if (mag02 > best) begin
      best      = mag02;
      best_pair = sjev_pkg::PAIR_02;
    end
    if (mag12 > best) begin
      best      = mag12;
      best_pair = sjev_pkg::PAIR_12;
    end
    case (best_pair)
      sjev_pkg::PAIR_02: begin
        sel_app = a00_q; sel_aqq = a22_q; sel_apq = a02_q; sel_rp = a01_q; sel_rq = a12_q;
      end
      sjev_pkg::PAIR_12: begin
        sel_app = a11_q; sel_aqq = a22_q; sel_apq = a12_q; sel_rp = a01_q; sel_rq = a02_q;
      end
      default: begin
        sel_app = a00_q; sel_aqq = a11_q; sel_apq = a01_q; sel_rp = a02_q; sel_rq = a12_q;
      end
    endcase
    diff = (DW + 1)'(sel_aqq) - (DW + 1)'(sel_app);
  end

  // Shared CORDIC stage for both vectoring and rotation.
  sjev_pkg::ang_t xs, ys, tab, mag_x, mag_y, mag_max;
  logic cw;

  always_comb begin
    xs      = cx_q >>> step_q;
    ys      = cy_q >>> step_q;
    tab     = sjev_pkg::ATAN_TAB[step_q];
    cw      = (state_q == sjev_pkg::ST_SITER) ? !cz_q[sjev_pkg::ANG_W-1] : !(cy_q > 0);
    mag_x   = cx_q[sjev_pkg::ANG_W-1] ? -cx_q : cx_q;
    mag_y   = cy_q[sjev_pkg::ANG_W-1] ? -cy_q : cy_q;
    mag_max = (mag_x > mag_y) ? mag_x : mag_y;
  end

  // Product schedule on the shared multiplier.
  sjev_pkg::mul_ctl_t ctl;

  always_comb begin
    ctl = '{opa: (DW + 1)'(c_q), opb: c_q, sub: 1'b0, first: 1'b1,
            dest: sjev_pkg::DST_CC};
    case (op_q)
      4'd0: ctl = '{(DW + 1)'(c_q), c_q, 1'b0, 1'b1, sjev_pkg::DST_CC};
      4'd1: ctl = '{(DW + 1)'(s_q), s_q, 1'b0, 1'b1, sjev_pkg::DST_SS};
      4'd2: ctl = '{{s_q, 1'b0}, c_q, 1'b0, 1'b1, sjev_pkg::DST_SC2};
      4'd3: ctl = '{(DW + 1)'(app_q), cc_q, 1'b0, 1'b1, sjev_pkg::DST_NONE};
      4'd4: ctl = '{(DW + 1)'(apq_q), sc2_q, 1'b1, 1'b0, sjev_pkg::DST_NONE};
      4'd5: ctl = '{(DW + 1)'(aqq_q), ss_q, 1'b0, 1'b0, sjev_pkg::DST_NPP};
      4'd6: ctl = '{(DW + 1)'(app_q), ss_q, 1'b0, 1'b1, sjev_pkg::DST_NONE};
      4'd7: ctl = '{(DW + 1)'(apq_q), sc2_q, 1'b0, 1'b0, sjev_pkg::DST_NONE};
      4'd8: ctl = '{(DW + 1)'(aqq_q), cc_q, 1'b0, 1'b0, sjev_pkg::DST_NQQ};
      4'd9: ctl = '{(DW + 1)'(rp_q), c_q, 1'b0, 1'b1, sjev_pkg::DST_NONE};
      4'd10: ctl = '{(DW + 1)'(rq_q), s_q, 1'b1, 1'b0, sjev_pkg::DST_NRP};
      4'd11: ctl = '{(DW + 1)'(rp_q), s_q, 1'b0, 1'b1, sjev_pkg::DST_NONE};
      4'd12: ctl = '{(DW + 1)'(rq_q), c_q, 1'b0, 1'b0, sjev_pkg::DST_NRQ};
      default: ;
    endcase
  end

  logic [DW-1:0] mul_ua, mul_ub;
  logic [64:0] rnd_sum;
  logic signed [sjev_pkg::ACC_W-1:0] term, acc_new, acc_sat;
  logic acc_clip;

  always_comb begin
    mul_ua  = ctl.opa[DW] ? DW'(-ctl.opa) : DW'(ctl.opa);
    mul_ub  = ctl.opb[DW-1] ? DW'(-ctl.opb) : DW'(ctl.opb);
    rnd_sum = {1'b0, prod_q} + (65'd1 << (sjev_pkg::SC_FRAC - 1));
    term    = neg_q ? -$signed({1'b0, rnd_sum[64:sjev_pkg::SC_FRAC]})
                    : $signed({1'b0, rnd_sum[64:sjev_pkg::SC_FRAC]});
    acc_new = ctl.first ? term : acc_q + term;
    acc_clip = 1'b0;
    acc_sat  = acc_new;
    if (acc_new > SatMax) begin
      acc_sat  = SatMax;
      acc_clip = 1'b1;
    end else if (acc_new < SatMin) begin
      acc_sat  = SatMin;
      acc_clip = 1'b1;
    end
  end

  // Sort the diagonal for the result.
  logic signed [DW-1:0] e0, e1, e2, t0, t1;

  always_comb begin
    e0 = a00_q;
    e1 = a11_q;
    e2 = a22_q;
    t0 = '0;
    t1 = '0;
    if (e0 > e1) begin t0 = e0; e0 = e1; e1 = t0; end
    if (e1 > e2) begin t1 = e1; e1 = e2; e2 = t1; end
    if (e0 > e1) begin t0 = e0; e0 = e1; e1 = t0; end
  end

  assign out_load = (state_q == sjev_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    pair_d  = pair_q;
    a00_d = a00_q; a01_d = a01_q; a02_d = a02_q;
    a11_d = a11_q; a12_d = a12_q; a22_d = a22_q;
    app_d = app_q; aqq_d = aqq_q; apq_d = apq_q; rp_d = rp_q; rq_d = rq_q;
    c_d = c_q; s_d = s_q; cc_d = cc_q; ss_d = ss_q; sc2_d = sc2_q;
    npp_d = npp_q; nqq_d = nqq_q; nrp_d = nrp_q; nrq_d = nrq_q;
    done_d = done_q; conv_d = conv_q; clip_d = clip_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    step_d = step_q; op_d = op_q; phase_d = phase_q;
    prod_d = prod_q; neg_d = neg_q; acc_d = acc_q;
    case (state_q)
      sjev_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          a00_d  = s_axis_tdata_i[0*DW +: DW];
          a01_d  = s_axis_tdata_i[1*DW +: DW];
          a02_d  = s_axis_tdata_i[2*DW +: DW];
          a11_d  = s_axis_tdata_i[3*DW +: DW];
          a12_d  = s_axis_tdata_i[4*DW +: DW];
          a22_d  = s_axis_tdata_i[5*DW +: DW];
          done_d = '0;
          conv_d = 1'b0;
          clip_d = 1'b0;
          state_d = sjev_pkg::ST_SEARCH;
        end
      end
      sjev_pkg::ST_SEARCH: begin
        if (best <= DW'(thr_q)) begin
          conv_d  = 1'b1;
          state_d = sjev_pkg::ST_FINISH;
        end else if (done_q >= rot_limit_q) begin
          state_d = sjev_pkg::ST_FINISH;
        end else begin
          pair_d = best_pair;
          app_d = sel_app; aqq_d = sel_aqq; apq_d = sel_apq; rp_d = sel_rp; rq_d = sel_rq;
          step_d = '0;
          if (diff == '0) begin
            cz_d    = sjev_pkg::PI_QUARTER;
            state_d = sjev_pkg::ST_SINIT;
          end else begin
            cx_d    = sjev_pkg::ang_t'(diff);
            cy_d    = sjev_pkg::ang_t'($signed({sel_apq, 1'b0}));
            state_d = sjev_pkg::ST_VNORM;
          end
        end
      end
      sjev_pkg::ST_VNORM: begin
        // Scale up until the larger magnitude reaches 2^58.
        if (mag_max < SmallMag) begin
          cx_d = cx_q <<< 8;
          cy_d = cy_q <<< 8;
        end else if (mag_max < NormMag) begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end else begin
          state_d = sjev_pkg::ST_VQUAD;
        end
      end
      sjev_pkg::ST_VQUAD: begin
        cz_d = '0;
        if (cx_q[sjev_pkg::ANG_W-1]) begin
          if (!cy_q[sjev_pkg::ANG_W-1]) begin
            cx_d = cy_q;
            cy_d = -cx_q;
            cz_d = sjev_pkg::PI_QUARTER <<< 1;
          end else begin
            cx_d = -cy_q;
            cy_d = cx_q;
            cz_d = -(sjev_pkg::PI_QUARTER <<< 1);
          end
        end
        state_d = sjev_pkg::ST_VITER;
      end
      sjev_pkg::ST_VITER, sjev_pkg::ST_SITER: begin
        if (cw) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - tab;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + tab;
        end
        step_d = step_q + 1'b1;
        if (step_q == sjev_pkg::STEP_W'(sjev_pkg::CORDIC_STEPS - 1)) begin
          step_d = '0;
          if (state_q == sjev_pkg::ST_VITER) begin
            // Half the vector angle is the rotation angle.
            cz_d    = cz_d >>> 1;
            state_d = sjev_pkg::ST_SINIT;
          end else begin
            state_d = sjev_pkg::ST_SCFIN;
          end
        end
      end
      sjev_pkg::ST_SINIT: begin
        cx_d    = sjev_pkg::GAIN_K <<< (sjev_pkg::ANG_FRAC - sjev_pkg::SC_FRAC);
        cy_d    = '0;
        step_d  = '0;
        state_d = sjev_pkg::ST_SITER;
      end
      sjev_pkg::ST_SCFIN: begin
        c_d     = DW'((cx_q + ScHalf) >>> (sjev_pkg::ANG_FRAC - sjev_pkg::SC_FRAC));
        s_d     = DW'((cy_q + ScHalf) >>> (sjev_pkg::ANG_FRAC - sjev_pkg::SC_FRAC));
        op_d    = '0;
        phase_d = 1'b0;
        state_d = sjev_pkg::ST_MUL;
      end
      sjev_pkg::ST_MUL: begin
        if (!phase_q) begin
          prod_d  = 64'(mul_ua) * 64'(mul_ub);
          neg_d   = ctl.opa[DW] ^ ctl.opb[DW-1] ^ ctl.sub;
          phase_d = 1'b1;
        end else begin
          acc_d   = acc_new;
          phase_d = 1'b0;
          case (ctl.dest)
            sjev_pkg::DST_CC:  cc_d  = DW'(acc_new);
            sjev_pkg::DST_SS:  ss_d  = DW'(acc_new);
            sjev_pkg::DST_SC2: sc2_d = DW'(acc_new);
            sjev_pkg::DST_NPP: begin npp_d = DW'(acc_sat); clip_d = clip_q | acc_clip; end
            sjev_pkg::DST_NQQ: begin nqq_d = DW'(acc_sat); clip_d = clip_q | acc_clip; end
            sjev_pkg::DST_NRP: begin nrp_d = DW'(acc_sat); clip_d = clip_q | acc_clip; end
            sjev_pkg::DST_NRQ: begin nrq_d = DW'(acc_sat); clip_d = clip_q | acc_clip; end
            default: ;
          endcase
          op_d = op_q + 1'b1;
          if (op_q == sjev_pkg::OP_W'(sjev_pkg::NUM_OPS - 1)) begin
            state_d = sjev_pkg::ST_WB;
          end
        end
      end
      sjev_pkg::ST_WB: begin
        case (pair_q)
          sjev_pkg::PAIR_02: begin
            a00_d = npp_q; a22_d = nqq_q; a02_d = '0; a01_d = nrp_q; a12_d = nrq_q;
          end
          sjev_pkg::PAIR_12: begin
            a11_d = npp_q; a22_d = nqq_q; a12_d = '0; a01_d = nrp_q; a02_d = nrq_q;
          end
          default: begin
            a00_d = npp_q; a11_d = nqq_q; a01_d = '0; a02_d = nrp_q; a12_d = nrq_q;
          end
        endcase
        done_d  = done_q + 1'b1;
        state_d = sjev_pkg::ST_SEARCH;
      end
      sjev_pkg::ST_FINISH: begin
        if (out_load) state_d = sjev_pkg::ST_IDLE;
      end
      default: state_d = sjev_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sjev_pkg::ST_IDLE;
      rot_limit_q <= sjev_pkg::ROT_LIMIT_RST;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      done_q      <= '0;
      conv_q      <= 1'b0;
      clip_q      <= 1'b0;
      step_q      <= '0;
      op_q        <= '0;
      phase_q     <= 1'b0;
      pair_q      <= sjev_pkg::PAIR_01;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      conv_q  <= conv_d;
      clip_q  <= clip_d;
      step_q  <= step_d;
      op_q    <= op_d;
      phase_q <= phase_d;
      pair_q  <= pair_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sjev_pkg::REG_ROT_LIMIT: rot_limit_q <= cfg_data_i[sjev_pkg::ROT_W-1:0];
          sjev_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[sjev_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a00_q <= a00_d; a01_q <= a01_d; a02_q <= a02_d;
    a11_q <= a11_d; a12_q <= a12_d; a22_q <= a22_d;
    app_q <= app_d; aqq_q <= aqq_d; apq_q <= apq_d; rp_q <= rp_d; rq_q <= rq_d;
    c_q <= c_d; s_q <= s_d; cc_q <= cc_d; ss_q <= ss_d; sc2_q <= sc2_d;
    npp_q <= npp_d; nqq_q <= nqq_d; nrp_q <= nrp_d; nrq_q <= nrq_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    prod_q <= prod_d; neg_q <= neg_d; acc_q <= acc_d;
    if (out_load) begin
      out_q <= {clip_q, conv_q, done_q, e2, e1, e0};
    end
  end

  assign s_axis_tready_o = (state_q == sjev_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  `SJEV_ASSERT_IMP(a_step_range,
    (state_q == sjev_pkg::ST_VITER || state_q == sjev_pkg::ST_SITER),
    (step_q < sjev_pkg::STEP_W'(sjev_pkg::CORDIC_STEPS)))
  `SJEV_ASSERT_IMP(a_op_range, (state_q == sjev_pkg::ST_MUL),
    (op_q < sjev_pkg::OP_W'(sjev_pkg::NUM_OPS)))
  `SJEV_ASSERT_NXT(a_pivot_zero,
    (state_q == sjev_pkg::ST_WB && pair_q == sjev_pkg::PAIR_01), (a01_q == '0))
  `SJEV_ASSERT_NXT(a_busy_after_accept, (s_axis_tvalid_i && s_axis_tready_o),
    (!s_axis_tready_o))

endmodule

FILE: sim/tb_symmetric_3x3_jacobi_eigenvalues.sv
// Testbench for the 3x3 Jacobi eigenvalue block: directed and random matrices,
// predicted by a fixed-point Jacobi model held here. Depends on sjev_pkg.
`timescale 1ns / 1ps
module tb_symmetric_3x3_jacobi_eigenvalues;

  typedef struct {
    logic signed [31:0] eig_low;
    logic signed [31:0] eig_mid;
    logic signed [31:0] eig_high;
    logic [5:0]         rotations_done;
    logic               converged;
    logic               saturated;
  } eig_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [sjev_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [sjev_pkg::CFG_W-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  // entry_00, entry_01, entry_02, entry_11, entry_12, entry_22 (32 bits each)
  logic [sjev_pkg::IN_W-1:0]    s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  // eig_low, eig_mid, eig_high (32 each), rotations_done (6), converged, saturated
  logic [sjev_pkg::OUT_W-1:0]   m_axis_tdata_o;

  logic [5:0]  rot_limit = 6'd50;
  logic [15:0] thresh = 16'd0;
  eig_res_t    eig_queue[$];
  int          fail_cnt = 0;
  bit          no_idle = 1'b0;

  symmetric_3x3_jacobi_eigenvalues u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // (a * b) / 2^30, rounded half away from zero
  function automatic longint mul_q30(longint a, longint b);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = ({64'd0, mag64(a)} * {64'd0, mag64(b)} + (128'd1 << 29)) >> 30;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clip32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint pivot_angle(longint x, longint y);
    longint unsigned m;
    longint z, t, xs, ys;
    m = mag64(x) > mag64(y) ? mag64(x) : mag64(y);
    z = 0;
    while (m < (64'd1 << 58)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 2 * longint'(sjev_pkg::PI_QUARTER);
      end else begin
        t = x; x = -y; y = t; z = -2 * longint'(sjev_pkg::PI_QUARTER);
      end
    end
    for (int i = 0; i < sjev_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(sjev_pkg::ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(sjev_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic eig_res_t jacobi_eigs(logic [sjev_pkg::IN_W-1:0] ent);
    longint a[3][3];
    longint e0, e1, e2, t, app, aqq, apq, diff, theta, x, y, z, xs, ys;
    longint c, s, cc, ss, sc2, rp, rq;
    longint unsigned best;
    int p, q, r;
    bit clip, conv;
    int done;
    eig_res_t res;
    clip = 0; conv = 0; done = 0;
    a[0][0] = longint'($signed(ent[31:0]));
    a[0][1] = longint'($signed(ent[63:32]));   a[1][0] = a[0][1];
    a[0][2] = longint'($signed(ent[95:64]));   a[2][0] = a[0][2];
    a[1][1] = longint'($signed(ent[127:96]));
    a[1][2] = longint'($signed(ent[159:128])); a[2][1] = a[1][2];
    a[2][2] = longint'($signed(ent[191:160]));
    forever begin
      best = 0; p = 0; q = 1;
      for (int i = 0; i < 3; i++)
        for (int j = i + 1; j < 3; j++)
          if (mag64(a[i][j]) > best) begin
            best = mag64(a[i][j]); p = i; q = j;
          end
      // threshold wins over the limit
      if (best <= thresh) begin
        conv = 1;
        break;
      end
      if (done >= rot_limit) break;
      app = a[p][p]; aqq = a[q][q]; apq = a[p][q];
      diff = aqq - app;
      theta = diff == 0 ? longint'(sjev_pkg::PI_QUARTER)
                        : pivot_angle(diff, 2 * apq) >>> 1;
      x = longint'(sjev_pkg::GAIN_K) <<< 30;
      y = 0;
      z = theta;
      for (int i = 0; i < sjev_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(sjev_pkg::ATAN_TAB[i]);
        end else begin
          x += ys; y -= xs; z += longint'(sjev_pkg::ATAN_TAB[i]);
        end
      end
      c = (x + (64'sd1 << 29)) >>> 30;
      s = (y + (64'sd1 << 29)) >>> 30;
      cc = mul_q30(c, c);
      ss = mul_q30(s, s);
      sc2 = mul_q30(2 * s, c);
      a[p][p] = clip32(mul_q30(app, cc) - mul_q30(apq, sc2) + mul_q30(aqq, ss), clip);
      a[q][q] = clip32(mul_q30(app, ss) + mul_q30(apq, sc2) + mul_q30(aqq, cc), clip);
      a[p][q] = 0; a[q][p] = 0;
      r = 3 - p - q;
      rp = a[r][p]; rq = a[r][q];
      a[r][p] = clip32(mul_q30(rp, c) - mul_q30(rq, s), clip); a[p][r] = a[r][p];
      a[r][q] = clip32(mul_q30(rp, s) + mul_q30(rq, c), clip); a[q][r] = a[r][q];
      done++;
    end
    e0 = a[0][0]; e1 = a[1][1]; e2 = a[2][2];
    if (e0 > e1) begin t = e0; e0 = e1; e1 = t; end
    if (e1 > e2) begin t = e1; e1 = e2; e2 = t; end
    if (e0 > e1) begin t = e0; e0 = e1; e1 = t; end
    res.eig_low = e0[31:0];
    res.eig_mid = e1[31:0];
    res.eig_high = e2[31:0];
    res.rotations_done = done[5:0];
    res.converged = conv;
    res.saturated = clip;
    return res;
  endfunction

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_matrix(logic [sjev_pkg::IN_W-1:0] ent);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= ent;
    do @(posedge clk_i); while (!s_axis_tready_o);
    eig_queue.push_back(jacobi_eigs(ent));
  endtask

  // drop valid first so the last matrix is not taken twice
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (eig_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // block is idle here; the testbench copy follows the write
  task automatic write_reg(logic [sjev_pkg::CFG_IDX_W-1:0] idx,
                           logic [sjev_pkg::CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sjev_pkg::REG_ROT_LIMIT) rot_limit = val[5:0];
    else if (idx == sjev_pkg::REG_THRESHOLD) thresh = val;
    @(posedge clk_i);
  endtask

  function automatic logic [sjev_pkg::IN_W-1:0] pack6(logic [31:0] a00, logic [31:0] a01,
      logic [31:0] a02, logic [31:0] a11, logic [31:0] a12, logic [31:0] a22);
    return {a22, a12, a11, a02, a01, a00};
  endfunction

  initial begin : result_check
    eig_res_t got, want;
    logic [sjev_pkg::OUT_W-1:0] d;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      d = m_axis_tdata_o;
      got.eig_low = d[31:0];
      got.eig_mid = d[63:32];
      got.eig_high = d[95:64];
      got.rotations_done = d[101:96];
      got.converged = d[102];
      got.saturated = d[103];
      if (eig_queue.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        want = eig_queue.pop_front();
        if (got.eig_low !== want.eig_low) begin
          $error("eig_low: expected %0d, got %0d", want.eig_low, got.eig_low); fail_cnt++;
        end
        if (got.eig_mid !== want.eig_mid) begin
          $error("eig_mid: expected %0d, got %0d", want.eig_mid, got.eig_mid); fail_cnt++;
        end
        if (got.eig_high !== want.eig_high) begin
          $error("eig_high: expected %0d, got %0d", want.eig_high, got.eig_high); fail_cnt++;
        end
        if (got.rotations_done !== want.rotations_done) begin
          $error("rotations_done: expected %0d, got %0d", want.rotations_done,
                 got.rotations_done);
          fail_cnt++;
        end
        if (got.converged !== want.converged) begin
          $error("converged: expected %0d, got %0d", want.converged, got.converged);
          fail_cnt++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
          fail_cnt++;
        end
      end
    end
  end

  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  task automatic test_reset_defaults();
    send_matrix(pack6(0, 0, 0, 0, 0, 0));
    send_matrix(pack6(MAXV, 0, 0, MINV, 0, 0));
    send_matrix(pack6(3 * ONE, ONE, 0, 2 * ONE, ONE, ONE));
    send_matrix(pack6(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_matrix(pack6(MINV, MINV, MINV, MINV, MINV, MINV));
    send_matrix(pack6(MAXV, MINV, MAXV, MINV, MINV, MAXV));
    drain();
  endtask

  task automatic test_special_cases();
    // first pair wins a tie on magnitude
    send_matrix(pack6(ONE, -ONE, ONE, 2 * ONE, -ONE, 5 * ONE));
    // equal diagonal pair, negative and positive off-diagonal
    send_matrix(pack6(ONE, -3 * ONE, 0, ONE, 0, 4 * ONE));
    send_matrix(pack6(-ONE, 7, 0, -ONE, 0, 0));
    send_matrix(pack6(ONE, 0, 0, ONE, ONE / 2, ONE));
    send_matrix(pack6(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 0));
    drain();
    write_reg(sjev_pkg::REG_ROT_LIMIT, 0);
    send_matrix(pack6(ONE, ONE, ONE, ONE, ONE, ONE));
    drain();
    write_reg(sjev_pkg::REG_ROT_LIMIT, 1);
    write_reg(sjev_pkg::REG_THRESHOLD, 16'hFFFF);
    send_matrix(pack6(0, 32'h0001_0000, 32'h0000_FFFF, 0, 32'hFFFF_0001, 0));
    send_matrix(pack6(ONE, 32'h0002_0000, 0, -ONE, 0, 0));
    drain();
    // wide writes keep the low bits; unused indexes do nothing
    write_reg(sjev_pkg::REG_ROT_LIMIT, 16'hFFFF);
    write_reg(sjev_pkg::REG_THRESHOLD, 0);
    write_reg(2'd2, 16'h0005);
    write_reg(2'd3, 16'hFFFF);
    send_matrix(pack6(ONE, MAXV, MINV, -ONE, MAXV, 0));
    send_matrix(pack6(5 * ONE, 3, 2, 5 * ONE, 1, 5 * ONE));
    drain();
  endtask

  function automatic logic [31:0] rand_entry(int kind, bit diag);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      2: return diag ? $urandom : $signed($urandom_range(0, 2 << 12)) - (1 << 12);
      default: return $signed($urandom_range(0, 2 * thresh + 1)) - thresh;
    endcase
  endfunction

  task automatic test_random();
    int kind;
    logic [31:0] d0;
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      no_idle = (ph % 4 == 3);
      write_reg(sjev_pkg::REG_ROT_LIMIT, ph == 5 ? 16'd63 : 16'($urandom_range(1, 20)));
      case (ph % 3)
        0: write_reg(sjev_pkg::REG_THRESHOLD, 0);
        1: write_reg(sjev_pkg::REG_THRESHOLD, 16'($urandom_range(0, 65535)));
        default: write_reg(sjev_pkg::REG_THRESHOLD, 16'($urandom_range(0, 255)));
      endcase
      for (int n = 0; n < (ph == 5 ? 15 : 50); n++) begin
        kind = $urandom_range(0, 4);
        d0 = rand_entry(kind, 1);
        if (kind == 4)
          send_matrix(pack6(d0, rand_entry(1, 0), rand_entry(1, 0), d0,
                            rand_entry(1, 0), rand_entry(0, 1)));
        else
          send_matrix(pack6(d0, rand_entry(kind, 0), rand_entry(kind, 0),
                            rand_entry(kind, 1), rand_entry(kind, 0), rand_entry(kind, 1)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_random();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && eig_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
